>>> design/keypad_code_lock_controller_macros.svh
// Assertion macros used by the keypad code lock controller core (kcl_core).
// Included by bare file name; no other dependencies.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kcl_pkg.sv
// Shared types and constants of the keypad code lock controller.
// No dependencies; used by every module of the block.
package kcl_pkg;

  // Code geometry
  localparam int CODE_DIGITS = 6;
  localparam int CODE_W      = 4 * CODE_DIGITS;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_FACTORY   = 3'd0;
  localparam logic [2:0] REG_ADMIN     = 3'd1;
  localparam logic [2:0] REG_UNLOCK    = 3'd2;
  localparam logic [2:0] REG_BACKLIGHT = 3'd3;
  localparam logic [2:0] REG_LOCKOUT   = 3'd4;
  localparam logic [2:0] REG_MAX_FAIL  = 3'd5;
  localparam logic [2:0] REG_RESTORE   = 3'd6;

  // Configuration reset values
  localparam logic [CODE_W-1:0] FACTORY_RST   = 24'd3281697;
  localparam logic [CODE_W-1:0] ADMIN_RST     = 24'd5373989;
  localparam logic [7:0]        UNLOCK_RST    = 8'd50;
  localparam logic [9:0]        BACKLIGHT_RST = 10'd150;
  localparam logic [9:0]        LOCKOUT_RST   = 10'd300;
  localparam logic [3:0]        MAX_FAIL_RST  = 4'd3;
  localparam logic [7:0]        RESTORE_RST   = 8'd14;

  // Input commands
  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_RESTORE   = 4'd10;
  localparam logic [3:0] KEY_DELETE    = 4'd11;
  localparam logic [3:0] KEY_CHANGE    = 4'd13;
  localparam logic [3:0] KEY_CLOSE     = 4'd14;
  localparam logic [3:0] KEY_CONFIRM   = 4'd15;

  // Lock modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd1;
  localparam logic [1:0] MODE_SECOND = 2'd2;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_UNLOCKED = 3'd1;
  localparam logic [2:0] EV_WRONG    = 3'd2;
  localparam logic [2:0] EV_ADMIN    = 3'd3;
  localparam logic [2:0] EV_CHANGED  = 3'd4;
  localparam logic [2:0] EV_MISMATCH = 3'd5;
  localparam logic [2:0] EV_RESTORED = 3'd6;
  localparam logic [2:0] EV_IGNORED  = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [CODE_W-1:0] factory_code;
    logic [CODE_W-1:0] admin_code;
    logic [7:0]        unlock_ticks;
    logic [9:0]        backlight_ticks;
    logic [9:0]        lockout_ticks;
    logic [3:0]        max_failures;
    logic [7:0]        restore_hold_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       relay_open;
    logic       backlight_on;
    logic       alarm_on;
    logic [1:0] mode;
    logic [2:0] digits_entered;
    logic [3:0] failure_count;
    logic [2:0] event_res;
  } res_t;

endpackage

>>> design/kcl_cfg_regs.sv
// APB-style configuration registers of the keypad code lock controller.
// Depends on kcl_pkg for the register set type, indexes and reset values.
module kcl_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0]  paddr,
  input  logic [kcl_pkg::DATA_W-1:0]  pwdata,
  output logic [kcl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output kcl_pkg::cfg_t               cfg_o
);

  kcl_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factory_code       <= kcl_pkg::FACTORY_RST;
      cfg_q.admin_code         <= kcl_pkg::ADMIN_RST;
      cfg_q.unlock_ticks       <= kcl_pkg::UNLOCK_RST;
      cfg_q.backlight_ticks    <= kcl_pkg::BACKLIGHT_RST;
      cfg_q.lockout_ticks      <= kcl_pkg::LOCKOUT_RST;
      cfg_q.max_failures       <= kcl_pkg::MAX_FAIL_RST;
      cfg_q.restore_hold_ticks <= kcl_pkg::RESTORE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        kcl_pkg::REG_FACTORY:   cfg_q.factory_code       <= pwdata[kcl_pkg::CODE_W-1:0];
        kcl_pkg::REG_ADMIN:     cfg_q.admin_code         <= pwdata[kcl_pkg::CODE_W-1:0];
        kcl_pkg::REG_UNLOCK:    cfg_q.unlock_ticks       <= pwdata[7:0];
        kcl_pkg::REG_BACKLIGHT: cfg_q.backlight_ticks    <= pwdata[9:0];
        kcl_pkg::REG_LOCKOUT:   cfg_q.lockout_ticks      <= pwdata[9:0];
        kcl_pkg::REG_MAX_FAIL:  cfg_q.max_failures       <= pwdata[3:0];
        kcl_pkg::REG_RESTORE:   cfg_q.restore_hold_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    case (reg_idx)
      kcl_pkg::REG_FACTORY:
        prdata = kcl_pkg::DATA_W'(cfg_q.factory_code);
      kcl_pkg::REG_ADMIN:
        prdata = kcl_pkg::DATA_W'(cfg_q.admin_code);
      kcl_pkg::REG_UNLOCK:
        prdata = kcl_pkg::DATA_W'(cfg_q.unlock_ticks);
      kcl_pkg::REG_BACKLIGHT:
        prdata = kcl_pkg::DATA_W'(cfg_q.backlight_ticks);
      kcl_pkg::REG_LOCKOUT:
        prdata = kcl_pkg::DATA_W'(cfg_q.lockout_ticks);
      kcl_pkg::REG_MAX_FAIL:
        prdata = kcl_pkg::DATA_W'(cfg_q.max_failures);
      kcl_pkg::REG_RESTORE:
        prdata = kcl_pkg::DATA_W'(cfg_q.restore_hold_ticks);
      default:
        prdata = '0;
    endcase
  end

endmodule

>>> design/kcl_core.sv
// Lock state and single-pass update logic of the keypad code lock controller.
// Depends on kcl_pkg and the assertion macro header.
`include "keypad_code_lock_controller_macros.svh"

module kcl_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [1:0]    cmd_i,
  input  logic [3:0]    key_i,
  input  kcl_pkg::cfg_t cfg_i,
  output kcl_pkg::res_t res_o
);

  localparam int CW = kcl_pkg::CODE_W;
  localparam int NW = kcl_pkg::CNT_W;
  localparam logic [NW-1:0] FULL = NW'(kcl_pkg::CODE_DIGITS);

  logic [CW-1:0] stored_q, stored_d;
  logic [CW-1:0] entry_q, entry_d;
  logic [CW-1:0] conf_q, conf_d;
  logic [NW-1:0] entry_cnt_q, entry_cnt_d;
  logic [NW-1:0] conf_cnt_q, conf_cnt_d;
  logic [1:0]    mode_q, mode_d;
  logic          relay_q, relay_d;
  logic [7:0]    unlock_tmr_q, unlock_tmr_d;
  logic          backlight_q, backlight_d;
  logic [9:0]    idle_tmr_q, idle_tmr_d;
  logic [3:0]    failures_q, failures_d;
  logic [9:0]    lockout_tmr_q, lockout_tmr_d;
  logic          alarm_q, alarm_d;
  logic          held_q, held_d;
  logic [7:0]    restore_tmr_q, restore_tmr_d;
  logic [2:0]    ev;

  logic [3:0]    fail_limit;
  logic          locked;
  logic          is_digit;
  logic          entry_full;
  logic          conf_full;
  logic          admin_hit;
  logic          stored_hit;
  logic [10:0]   idle_inc;
  logic [8:0]    unlock_inc;
  logic [10:0]   lockout_inc;
  logic [8:0]    restore_inc;

  // Decode the current state
  assign fail_limit  = (cfg_i.max_failures == 4'd0) ? 4'd1 : cfg_i.max_failures;
  assign locked      = failures_q >= fail_limit;
  assign is_digit    = key_i <= kcl_pkg::KEY_DIGIT_MAX;
  assign entry_full  = entry_cnt_q == FULL;
  assign conf_full   = conf_cnt_q == FULL;
  assign admin_hit   = entry_full && (entry_q == cfg_i.admin_code);
  assign stored_hit  = entry_full && (entry_q == stored_q);
  assign idle_inc    = {1'b0, idle_tmr_q} + 11'd1;
  assign unlock_inc  = {1'b0, unlock_tmr_q} + 9'd1;
  assign lockout_inc = {1'b0, lockout_tmr_q} + 11'd1;
  assign restore_inc = {1'b0, restore_tmr_q} + 9'd1;

  // Work out the next state and the event of one item
  always_comb begin
    stored_d      = stored_q;
    entry_d       = entry_q;
    conf_d        = conf_q;
    entry_cnt_d   = entry_cnt_q;
    conf_cnt_d    = conf_cnt_q;
    mode_d        = mode_q;
    relay_d       = relay_q;
    unlock_tmr_d  = unlock_tmr_q;
    backlight_d   = backlight_q;
    idle_tmr_d    = idle_tmr_q;
    failures_d    = failures_q;
    lockout_tmr_d = lockout_tmr_q;
    alarm_d       = alarm_q;
    held_d        = held_q;
    restore_tmr_d = restore_tmr_q;
    ev            = kcl_pkg::EV_NONE;

    if (step_i) begin
      case (cmd_i)
        kcl_pkg::CMD_KEY: begin
          if (locked) begin
            ev = kcl_pkg::EV_IGNORED;
          end else if (!backlight_q) begin
            idle_tmr_d  = '0;
            backlight_d = 1'b1;
            ev          = kcl_pkg::EV_IGNORED;
          end else begin
            idle_tmr_d = '0;
            case (mode_q)
              kcl_pkg::MODE_NORMAL: begin
                if (key_i == kcl_pkg::KEY_CLOSE) begin
                  relay_d      = 1'b0;
                  unlock_tmr_d = '0;
                end else if (key_i == kcl_pkg::KEY_RESTORE) begin
                  held_d        = 1'b1;
                  restore_tmr_d = '0;
                end else if (is_digit) begin
                  if (!entry_full) begin
                    entry_d     = {entry_q[CW-5:0], key_i};
                    entry_cnt_d = entry_cnt_q + NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_DELETE) begin
                  if (entry_cnt_q != '0) begin
                    entry_d     = {4'd0, entry_q[CW-1:4]};
                    entry_cnt_d = entry_cnt_q - NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_CONFIRM) begin
                  if (admin_hit) begin
                    ev = kcl_pkg::EV_ADMIN;
                  end else if (stored_hit) begin
                    relay_d      = 1'b1;
                    unlock_tmr_d = '0;
                    ev           = kcl_pkg::EV_UNLOCKED;
                  end else begin
                    if (failures_q != 4'hF) failures_d = failures_q + 4'd1;
                    ev = kcl_pkg::EV_WRONG;
                  end
                  entry_d     = '0;
                  conf_d      = '0;
                  entry_cnt_d = '0;
                  conf_cnt_d  = '0;
                end else if (key_i == kcl_pkg::KEY_CHANGE && relay_q) begin
                  mode_d      = kcl_pkg::MODE_FIRST;
                  entry_d     = '0;
                  conf_d      = '0;
                  entry_cnt_d = '0;
                  conf_cnt_d  = '0;
                end
              end
              kcl_pkg::MODE_FIRST: begin
                if (is_digit) begin
                  if (!entry_full) begin
                    entry_d     = {entry_q[CW-5:0], key_i};
                    entry_cnt_d = entry_cnt_q + NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_DELETE) begin
                  if (entry_cnt_q != '0) begin
                    entry_d     = {4'd0, entry_q[CW-1:4]};
                    entry_cnt_d = entry_cnt_q - NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_CONFIRM) begin
                  conf_d     = '0;
                  conf_cnt_d = '0;
                  mode_d     = kcl_pkg::MODE_SECOND;
                end
              end
              default: begin
                if (is_digit) begin
                  if (!conf_full) begin
                    conf_d     = {conf_q[CW-5:0], key_i};
                    conf_cnt_d = conf_cnt_q + NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_DELETE) begin
                  if (conf_cnt_q != '0) begin
                    conf_d     = {4'd0, conf_q[CW-1:4]};
                    conf_cnt_d = conf_cnt_q - NW'(1);
                  end
                end else if (key_i == kcl_pkg::KEY_CONFIRM) begin
                  if (entry_full && conf_full && entry_q == conf_q) begin
                    stored_d = entry_q;
                    ev       = kcl_pkg::EV_CHANGED;
                  end else begin
                    ev = kcl_pkg::EV_MISMATCH;
                  end
                  mode_d      = kcl_pkg::MODE_NORMAL;
                  entry_d     = '0;
                  conf_d      = '0;
                  entry_cnt_d = '0;
                  conf_cnt_d  = '0;
                end
              end
            endcase
          end
        end
        kcl_pkg::CMD_TICK: begin
          // Backlight idle timeout
          if (backlight_q) begin
            if (idle_inc >= {1'b0, cfg_i.backlight_ticks}) begin
              idle_tmr_d  = '0;
              backlight_d = 1'b0;
            end else begin
              idle_tmr_d = idle_inc[9:0];
            end
          end
          // Relay open interval
          if (relay_q) begin
            if (unlock_inc >= {1'b0, cfg_i.unlock_ticks}) begin
              unlock_tmr_d = '0;
              relay_d      = 1'b0;
            end else begin
              unlock_tmr_d = unlock_inc[7:0];
            end
          end else begin
            unlock_tmr_d = '0;
          end
          // Alarm lockout
          if (locked) begin
            if (lockout_inc >= {1'b0, cfg_i.lockout_ticks}) begin
              lockout_tmr_d = '0;
              alarm_d       = 1'b0;
              failures_d    = '0;
            end else begin
              lockout_tmr_d = lockout_inc[9:0];
              alarm_d       = !alarm_q;
            end
          end
          // Long hold of the restore key
          if (held_q) begin
            if (restore_inc >= {1'b0, cfg_i.restore_hold_ticks}) begin
              restore_tmr_d = '0;
              held_d        = 1'b0;
              stored_d      = cfg_i.factory_code;
              ev            = kcl_pkg::EV_RESTORED;
            end else begin
              restore_tmr_d = restore_inc[7:0];
            end
          end
        end
        kcl_pkg::CMD_RELEASE: begin
          held_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold the lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q      <= kcl_pkg::FACTORY_RST;
      entry_q       <= '0;
      conf_q        <= '0;
      entry_cnt_q   <= '0;
      conf_cnt_q    <= '0;
      mode_q        <= kcl_pkg::MODE_NORMAL;
      relay_q       <= 1'b0;
      unlock_tmr_q  <= '0;
      backlight_q   <= 1'b1;
      idle_tmr_q    <= '0;
      failures_q    <= '0;
      lockout_tmr_q <= '0;
      alarm_q       <= 1'b0;
      held_q        <= 1'b0;
      restore_tmr_q <= '0;
    end else begin
      stored_q      <= stored_d;
      entry_q       <= entry_d;
      conf_q        <= conf_d;
      entry_cnt_q   <= entry_cnt_d;
      conf_cnt_q    <= conf_cnt_d;
      mode_q        <= mode_d;
      relay_q       <= relay_d;
      unlock_tmr_q  <= unlock_tmr_d;
      backlight_q   <= backlight_d;
      idle_tmr_q    <= idle_tmr_d;
      failures_q    <= failures_d;
      lockout_tmr_q <= lockout_tmr_d;
      alarm_q       <= alarm_d;
      held_q        <= held_d;
      restore_tmr_q <= restore_tmr_d;
    end
  end

  // Build the result of the item from the updated state
  always_comb begin
    res_o.relay_open     = relay_d;
    res_o.backlight_on   = backlight_d;
    res_o.alarm_on       = alarm_d;
    res_o.mode           = mode_d;
    res_o.digits_entered = 3'((mode_d == kcl_pkg::MODE_SECOND) ? conf_cnt_d : entry_cnt_d);
    res_o.failure_count  = failures_d;
    res_o.event_res      = ev;
  end

  `KCL_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, entry_cnt_q <= FULL && conf_cnt_q <= FULL, "entry count beyond code length")
  `KCL_ASSERT_NOW(a_relay_tmr, clk_i, rst_ni, !relay_q, unlock_tmr_q == '0, "unlock timer runs with relay closed")
  `KCL_ASSERT_NEXT(a_restore, clk_i, rst_ni, step_i && ev == kcl_pkg::EV_RESTORED, stored_q == $past(cfg_i.factory_code), "restore did not load factory code")

endmodule

>>> design/keypad_code_lock_controller.sv
// Keypad code lock controller: top level with input and result registers.
// Depends on kcl_pkg, kcl_cfg_regs and kcl_core.
//
//   Input channel (in_valid_i / in_stall_o) carries one event per item:
//   command_i 0 key press, 1 200 ms tick, 2 key release, with key_code_i.
//   Result channel (out_valid_o / out_stall_i) returns exactly one item per
//   input item: relay, backlight, alarm, mode, digit count, failures, event.
//   An item is taken at a rising edge with valid high and stall low.
//   The item waits in the input register, passes the lock update and is
//   loaded into the result register, from which it shows as a valid result.
//   Throughput is one item per cycle while the receiver does not stall; the
//   single-pass update between the input and result registers sets that rate.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; the input then stalls until the
//   result is taken.
//   Reset (rst_ni low, asynchronous) empties both registers, loads the
//   configuration defaults and the factory code as stored code, closes the
//   relay, turns the backlight on and clears every timer and count.
//   The user writes configuration over the APB-style port only while no item
//   is in flight; the block does not enforce this. pready is always high.
module keypad_code_lock_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [3:0]                 key_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       relay_open_o,
  output logic                       backlight_on_o,
  output logic                       alarm_on_o,
  output logic [1:0]                 mode_o,
  output logic [2:0]                 digits_entered_o,
  output logic [3:0]                 failure_count_o,
  output logic [2:0]                 event_res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic [kcl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  kcl_pkg::cfg_t cfg;
  kcl_pkg::res_t res_d, res_q;
  logic          in_valid_q, in_valid_d;
  logic [1:0]    cmd_q;
  logic [3:0]    key_q;
  logic          out_valid_q, out_valid_d;
  logic          advance;
  logic          in_take;

  // Move the held item on when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  kcl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kcl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .key_i  (key_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Track occupancy of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= command_i;
      key_q <= key_code_i;
    end
  end

  // Load the result item
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign relay_open_o     = res_q.relay_open;
  assign backlight_on_o   = res_q.backlight_on;
  assign alarm_on_o       = res_q.alarm_on;
  assign mode_o           = res_q.mode;
  assign digits_entered_o = res_q.digits_entered;
  assign failure_count_o  = res_q.failure_count;
  assign event_res_o      = res_q.event_res;

endmodule

>>> sim/keypad_code_lock_controller_tb.sv
// Self-checking testbench for the keypad code lock controller.
// Depends on kcl_pkg and the keypad_code_lock_controller RTL.
// Predicts each status item from key and tick items and checks it field by field.
module keypad_code_lock_controller_tb;

  // Key code with no function on the keypad
  localparam logic [3:0] KEY_SPARE = 4'd12;

  // Predicted lock state, held at the block's widths
  typedef struct packed {
    logic [kcl_pkg::CODE_W-1:0] stored;
    logic [kcl_pkg::CODE_W-1:0] entry;
    logic [kcl_pkg::CNT_W-1:0]  entry_n;
    logic [kcl_pkg::CODE_W-1:0] confirm;
    logic [kcl_pkg::CNT_W-1:0]  confirm_n;
    logic [1:0]                 mode;
    logic                       relay;
    logic [7:0]                 unlock_t;
    logic                       backlight;
    logic [9:0]                 idle_t;
    logic [3:0]                 failures;
    logic [9:0]                 lockout_t;
    logic                       alarm;
    logic                       held;
    logic [7:0]                 restore_t;
  } lock_state_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  command_i = kcl_pkg::CMD_TICK;
  logic [3:0]                  key_code_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        relay_open_o;
  logic                        backlight_on_o;
  logic                        alarm_on_o;
  logic [1:0]                  mode_o;
  logic [2:0]                  digits_entered_o;
  logic [3:0]                  failure_count_o;
  logic [2:0]                  event_res_o;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [kcl_pkg::ADDR_W-1:0]  paddr = '0;
  logic [kcl_pkg::DATA_W-1:0]  pwdata = '0;
  logic [kcl_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  kcl_pkg::cfg_t cfg;
  lock_state_t   lock_st;
  lock_state_t   gen_st;
  logic [5:0]    key_event_q[$];
  kcl_pkg::res_t due_status_q[$];
  int            gen_counted;
  int            mismatches = 0;
  int            accepted = 0;
  int            event_tally[8];
  int            hold_off_asked = 0;
  int            hold_off_seen = 0;
  int            hold_off_left = 0;
  int            rx_cycle = 0;
  int            rx_style = 0;
  int            burst_left = 0;
  int            gap_left = 0;

  keypad_code_lock_controller u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .key_code_i       (key_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .relay_open_o     (relay_open_o),
    .backlight_on_o   (backlight_on_o),
    .alarm_on_o       (alarm_on_o),
    .mode_o           (mode_o),
    .digits_entered_o (digits_entered_o),
    .failure_count_o  (failure_count_o),
    .event_res_o      (event_res_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk_i = ~clk_i;

  // Lock state straight after reset
  function automatic lock_state_t reset_lock_state();
    lock_state_t st;
    st = '0;
    st.stored = kcl_pkg::FACTORY_RST;
    st.mode = kcl_pkg::MODE_NORMAL;
    st.backlight = 1'b1;
    return st;
  endfunction

  function automatic logic [3:0] fail_limit(input logic [3:0] limit);
    return (limit == 4'd0) ? 4'd1 : limit;
  endfunction

  // Shift a digit in at the bottom unless the buffer is full
  function automatic void push_digit(inout logic [kcl_pkg::CODE_W-1:0] digits,
                                     inout logic [kcl_pkg::CNT_W-1:0] n,
                                     input logic [3:0] d);
    if (n >= kcl_pkg::CODE_DIGITS) return;
    digits = {digits[kcl_pkg::CODE_W-5:0], d};
    n = n + 1'b1;
  endfunction

  // Drop the newest digit, if there is one
  function automatic void pop_digit(inout logic [kcl_pkg::CODE_W-1:0] digits,
                                    inout logic [kcl_pkg::CNT_W-1:0] n);
    if (n == 0) return;
    digits = {4'h0, digits[kcl_pkg::CODE_W-1:4]};
    n = n - 1'b1;
  endfunction

  function automatic void clear_entries(inout lock_state_t st);
    st.entry = '0;
    st.confirm = '0;
    st.entry_n = '0;
    st.confirm_n = '0;
  endfunction

  // Advance the lock by one item and return the status it reports
  function automatic kcl_pkg::res_t next_lock_status(inout lock_state_t st,
                                                     input logic [1:0] cmd,
                                                     input logic [3:0] key);
    kcl_pkg::res_t r;
    logic [2:0] ev;
    ev = kcl_pkg::EV_NONE;
    if (cmd == kcl_pkg::CMD_KEY) begin
      if (st.failures >= fail_limit(cfg.max_failures)) begin
        ev = kcl_pkg::EV_IGNORED;
      end else begin
        st.idle_t = '0;
        if (!st.backlight) begin
          st.backlight = 1'b1;
          ev = kcl_pkg::EV_IGNORED;
        end else if (st.mode == kcl_pkg::MODE_NORMAL) begin
          if (key == kcl_pkg::KEY_CLOSE) begin
            st.relay = 1'b0;
            st.unlock_t = '0;
          end else if (key == kcl_pkg::KEY_RESTORE) begin
            st.held = 1'b1;
            st.restore_t = '0;
          end else if (key <= kcl_pkg::KEY_DIGIT_MAX) begin
            push_digit(st.entry, st.entry_n, key);
          end else if (key == kcl_pkg::KEY_DELETE) begin
            pop_digit(st.entry, st.entry_n);
          end else if (key == kcl_pkg::KEY_CONFIRM) begin
            // Admin code wins over the stored code; short entries never match
            if (st.entry_n == kcl_pkg::CODE_DIGITS && st.entry == cfg.admin_code) begin
              ev = kcl_pkg::EV_ADMIN;
            end else if (st.entry_n == kcl_pkg::CODE_DIGITS && st.entry == st.stored) begin
              st.relay = 1'b1;
              st.unlock_t = '0;
              ev = kcl_pkg::EV_UNLOCKED;
            end else begin
              if (st.failures < 4'd15) st.failures = st.failures + 1'b1;
              ev = kcl_pkg::EV_WRONG;
            end
            clear_entries(st);
          end else if (key == kcl_pkg::KEY_CHANGE && st.relay) begin
            st.mode = kcl_pkg::MODE_FIRST;
            clear_entries(st);
          end
        end else if (st.mode == kcl_pkg::MODE_FIRST) begin
          if (key <= kcl_pkg::KEY_DIGIT_MAX) push_digit(st.entry, st.entry_n, key);
          else if (key == kcl_pkg::KEY_DELETE) pop_digit(st.entry, st.entry_n);
          else if (key == kcl_pkg::KEY_CONFIRM) begin
            st.confirm = '0;
            st.confirm_n = '0;
            st.mode = kcl_pkg::MODE_SECOND;
          end
        end else begin
          if (key <= kcl_pkg::KEY_DIGIT_MAX) push_digit(st.confirm, st.confirm_n, key);
          else if (key == kcl_pkg::KEY_DELETE) pop_digit(st.confirm, st.confirm_n);
          else if (key == kcl_pkg::KEY_CONFIRM) begin
            if (st.entry_n == kcl_pkg::CODE_DIGITS && st.confirm_n == kcl_pkg::CODE_DIGITS &&
                st.entry == st.confirm) begin
              st.stored = st.entry;
              ev = kcl_pkg::EV_CHANGED;
            end else begin
              ev = kcl_pkg::EV_MISMATCH;
            end
            st.mode = kcl_pkg::MODE_NORMAL;
            clear_entries(st);
          end
        end
      end
    end else if (cmd == kcl_pkg::CMD_TICK) begin
      if (st.backlight) begin
        st.idle_t = st.idle_t + 1'b1;
        if (st.idle_t >= cfg.backlight_ticks) begin
          st.idle_t = '0;
          st.backlight = 1'b0;
        end
      end
      if (st.relay) begin
        st.unlock_t = st.unlock_t + 1'b1;
        if (st.unlock_t >= cfg.unlock_ticks) begin
          st.unlock_t = '0;
          st.relay = 1'b0;
        end
      end else begin
        st.unlock_t = '0;
      end
      if (st.failures >= fail_limit(cfg.max_failures)) begin
        st.lockout_t = st.lockout_t + 1'b1;
        st.alarm = ~st.alarm;
        if (st.lockout_t >= cfg.lockout_ticks) begin
          st.lockout_t = '0;
          st.alarm = 1'b0;
          st.failures = '0;
        end
      end
      if (st.held) begin
        st.restore_t = st.restore_t + 1'b1;
        if (st.restore_t >= cfg.restore_hold_ticks) begin
          st.restore_t = '0;
          st.held = 1'b0;
          st.stored = cfg.factory_code;
          ev = kcl_pkg::EV_RESTORED;
        end
      end
    end else if (cmd == kcl_pkg::CMD_RELEASE) begin
      st.held = 1'b0;
    end
    r.relay_open = st.relay;
    r.backlight_on = st.backlight;
    r.alarm_on = st.alarm;
    r.mode = st.mode;
    r.digits_entered = (st.mode == kcl_pkg::MODE_SECOND) ? st.confirm_n : st.entry_n;
    r.failure_count = st.failures;
    r.event_res = ev;
    return r;
  endfunction

  function automatic logic [kcl_pkg::CODE_W-1:0] rand_bcd();
    logic [kcl_pkg::CODE_W-1:0] code;
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++)
      code[4*i +: 4] = 4'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX));
    return code;
  endfunction

  // Queue an item, tracking the state the lock will be in once it is taken
  task automatic offer(input logic [1:0] cmd, input logic [3:0] key);
    kcl_pkg::res_t r;
    r = next_lock_status(gen_st, cmd, key);
    if (r.event_res != kcl_pkg::EV_IGNORED) gen_counted++;
    key_event_q.push_back({cmd, key});
  endtask

  // Type the leading digits of a code, most significant first
  task automatic type_code(input logic [kcl_pkg::CODE_W-1:0] code, input int count);
    for (int i = kcl_pkg::CODE_DIGITS - 1; i >= kcl_pkg::CODE_DIGITS - count; i--)
      offer(kcl_pkg::CMD_KEY, code[4*i +: 4]);
  endtask

  // Hold the sender until every queued item has been answered
  task automatic wait_drained();
    do @(negedge clk_i);
    while (key_event_q.size() != 0 || in_valid_i || due_status_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Write one register: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [kcl_pkg::DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      kcl_pkg::REG_FACTORY:   cfg.factory_code = value[kcl_pkg::CODE_W-1:0];
      kcl_pkg::REG_ADMIN:     cfg.admin_code = value[kcl_pkg::CODE_W-1:0];
      kcl_pkg::REG_UNLOCK:    cfg.unlock_ticks = value[7:0];
      kcl_pkg::REG_BACKLIGHT: cfg.backlight_ticks = value[9:0];
      kcl_pkg::REG_LOCKOUT:   cfg.lockout_ticks = value[9:0];
      kcl_pkg::REG_MAX_FAIL:  cfg.max_failures = value[3:0];
      kcl_pkg::REG_RESTORE:   cfg.restore_hold_ticks = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [kcl_pkg::CODE_W-1:0] factory,
                            input logic [kcl_pkg::CODE_W-1:0] admin,
                            input int unlock, input int backlight, input int lockout,
                            input int max_fail, input int restore);
    write_reg(kcl_pkg::REG_FACTORY, kcl_pkg::DATA_W'(factory));
    write_reg(kcl_pkg::REG_ADMIN, kcl_pkg::DATA_W'(admin));
    write_reg(kcl_pkg::REG_UNLOCK, unlock);
    write_reg(kcl_pkg::REG_BACKLIGHT, backlight);
    write_reg(kcl_pkg::REG_LOCKOUT, lockout);
    write_reg(kcl_pkg::REG_MAX_FAIL, max_fail);
    write_reg(kcl_pkg::REG_RESTORE, restore);
  endtask

  // Random key sessions, shaped by where the lock will be when each one starts
  task automatic gen_random(input int target);
    int pick;
    int n;
    logic [kcl_pkg::CODE_W-1:0] code;
    gen_counted = 0;
    while (gen_counted < target) begin
      pick = $urandom_range(0, 99);
      if (gen_st.failures >= fail_limit(cfg.max_failures)) begin
        // lockout: mostly ticks, the odd key press bounces off
        if (pick < 85) offer(kcl_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
        else offer(kcl_pkg::CMD_KEY, 4'($urandom_range(0, 15)));
      end else if (!gen_st.backlight) begin
        offer(kcl_pkg::CMD_KEY, 4'($urandom_range(0, 15)));
      end else if (gen_st.mode != kcl_pkg::MODE_NORMAL) begin
        if (pick < 60) offer(kcl_pkg::CMD_KEY, 4'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
        else if (pick < 72) offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_DELETE);
        else if (pick < 88) offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
        else offer(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
      end else if (pick < 30) begin
        // open with the stored code, sometimes after a corrected slip
        if (pick < 6) begin
          offer(kcl_pkg::CMD_KEY, 4'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
          offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_DELETE);
        end
        type_code(gen_st.stored, kcl_pkg::CODE_DIGITS);
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
      end else if (pick < 48 && gen_st.relay) begin
        // change the code: two entries, mostly matching
        code = rand_bcd();
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CHANGE);
        type_code(code, kcl_pkg::CODE_DIGITS);
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
        n = $urandom_range(0, 9);
        if (n < 7) type_code(code, kcl_pkg::CODE_DIGITS);
        else if (n < 8) type_code(code, $urandom_range(0, kcl_pkg::CODE_DIGITS - 1));
        else type_code(rand_bcd(), kcl_pkg::CODE_DIGITS);
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
      end else if (pick < 54) begin
        type_code(cfg.admin_code, kcl_pkg::CODE_DIGITS);
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
      end else if (pick < 66) begin
        // wrong or short entry
        n = $urandom_range(0, kcl_pkg::CODE_DIGITS + 2);
        repeat (n) offer(kcl_pkg::CMD_KEY, 4'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
      end else if (pick < 72) begin
        // hold restore for some ticks, then let go
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_RESTORE);
        n = (cfg.restore_hold_ticks < 20) ? cfg.restore_hold_ticks + 1 : 20;
        repeat ($urandom_range(0, n)) offer(kcl_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
        offer(kcl_pkg::CMD_RELEASE, 4'($urandom_range(0, 15)));
      end else if (pick < 76) begin
        offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CLOSE);
      end else if (pick < 90) begin
        offer(kcl_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
      end else begin
        offer(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Sender: bursts of items with random gaps; predict each item as it is taken
  always @(posedge clk_i) begin
    kcl_pkg::res_t r;
    logic [5:0] nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r = next_lock_status(lock_st, command_i, key_code_i);
        due_status_q.push_back(r);
        event_tally[r.event_res]++;
        accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (key_event_q.size() > 0) begin
          nxt = key_event_q.pop_front();
          command_i <= nxt[5:4];
          key_code_i <= nxt[3:0];
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall_i <= 1'b1;
      end else if (hold_off_asked != hold_off_seen) begin
        hold_off_seen = hold_off_asked;
        hold_off_left = 60;
        out_stall_i <= 1'b1;
      end else begin
        if (rx_cycle % 97 == 0) rx_style = $urandom_range(0, 3);
        case (rx_style)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 35);
          2: out_stall_i <= (rx_cycle % 5 < 2);
          default: out_stall_i <= ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each status item taken with the oldest prediction
  always @(posedge clk_i) begin
    kcl_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_status_q.size() == 0) begin
        $display("%0t: status item with none expected, event %0d", $time, event_res_o);
        mismatches++;
      end else begin
        want = due_status_q.pop_front();
        check_field("relay_open", want.relay_open, relay_open_o);
        check_field("backlight_on", want.backlight_on, backlight_on_o);
        check_field("alarm_on", want.alarm_on, alarm_on_o);
        check_field("mode", want.mode, mode_o);
        check_field("digits_entered", want.digits_entered, digits_entered_o);
        check_field("failure_count", want.failure_count, failure_count_o);
        check_field("event_res", want.event_res, event_res_o);
      end
    end
  end

  // Stimulus
  initial begin
    cfg = '{kcl_pkg::FACTORY_RST, kcl_pkg::ADMIN_RST, kcl_pkg::UNLOCK_RST,
            kcl_pkg::BACKLIGHT_RST, kcl_pkg::LOCKOUT_RST, kcl_pkg::MAX_FAIL_RST,
            kcl_pkg::RESTORE_RST};
    lock_st = reset_lock_state();
    gen_st = reset_lock_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Edge cases with short unlock, lockout and restore timers, a long backlight timer and a failure limit of two
    set_config(24'h999999, 24'h000000, 2, 1023, 2, 2, 2);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_DELETE);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CLOSE);
    offer(kcl_pkg::CMD_KEY, KEY_SPARE);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CHANGE);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
    type_code(gen_st.stored, kcl_pkg::CODE_DIGITS);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_DIGIT_MAX);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CHANGE);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_RESTORE);
    offer(kcl_pkg::CMD_RELEASE, kcl_pkg::KEY_RESTORE);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_RESTORE);
    offer(kcl_pkg::CMD_TICK, 4'd0);
    offer(kcl_pkg::CMD_TICK, 4'd0);
    offer(kcl_pkg::CMD_KEY, kcl_pkg::KEY_CONFIRM);
    offer(kcl_pkg::CMD_KEY, 4'd0);
    offer(kcl_pkg::CMD_TICK, 4'd0);
    offer(kcl_pkg::CMD_TICK, 4'd0);
    wait_drained();

    // Moderate timers, long receiver hold-off with the queue full
    set_config(rand_bcd(), rand_bcd(), 6, 40, 8, 3, 4);
    gen_random(250);
    @(negedge clk_i);
    hold_off_asked++;
    wait_drained();

    // Every count at its minimum
    set_config(24'h000000, 24'h999999, 1, 1, 1, 1, 1);
    gen_random(150);
    wait_drained();

    // Every count at its maximum
    set_config(rand_bcd(), rand_bcd(), 255, 1023, 1023, 15, 255);
    gen_random(200);
    wait_drained();

    // Random mid-range settings, split by a full drain
    set_config(rand_bcd(), rand_bcd(), $urandom_range(2, 20), $urandom_range(20, 100),
               $urandom_range(3, 20), $urandom_range(2, 5), $urandom_range(2, 10));
    gen_random(125);
    wait_drained();
    gen_random(125);
    @(negedge clk_i);
    hold_off_asked++;
    wait_drained();
    repeat (5) @(negedge clk_i);

    $display("Summary: %0d key and tick items over five register settings, edge cases first.",
             accepted);
    $display("Events: %0d unlocked, %0d wrong, %0d admin, %0d changed, %0d mismatched, %0d %s",
             event_tally[kcl_pkg::EV_UNLOCKED], event_tally[kcl_pkg::EV_WRONG],
             event_tally[kcl_pkg::EV_ADMIN], event_tally[kcl_pkg::EV_CHANGED],
             event_tally[kcl_pkg::EV_MISMATCH], event_tally[kcl_pkg::EV_RESTORED],
             "restored");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
